[sv/tsmq_pkg.sv]
// shared constants, codes and types of the timestamp sorted message queue
package tsmq_pkg;

  // parameter defaults
  localparam int DEPTH_DEF       = 16;
  localparam int STAMP_BITS_DEF  = 32;
  localparam int SENDER_BITS_DEF = 8;

  // fixed field widths
  localparam int MODE_W   = 3;
  localparam int KIND_W   = 8;
  localparam int POS_W    = 4;
  localparam int FOUND_W  = 4;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 3;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request modes
  localparam mode_t MODE_INSERT = 3'd0;
  localparam mode_t MODE_POP    = 3'd1;
  localparam mode_t MODE_PEEK   = 3'd2;
  localparam mode_t MODE_REMOVE = 3'd3;
  localparam mode_t MODE_FIND   = 3'd4;

  // result status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_EMPTY     = 3'd1;
  localparam status_t ST_BAD_INDEX = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  // datapath operations issued by the controller
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t DP_NOP     = 4'd0;
  localparam dp_op_t DP_LOAD    = 4'd1;
  localparam dp_op_t DP_PROBE   = 4'd2;
  localparam dp_op_t DP_COMPARE = 4'd3;
  localparam dp_op_t DP_SHUP    = 4'd4;
  localparam dp_op_t DP_PUT     = 4'd5;
  localparam dp_op_t DP_FETCH   = 4'd6;
  localparam dp_op_t DP_TAKE    = 4'd7;
  localparam dp_op_t DP_SHDN    = 4'd8;
  localparam dp_op_t DP_SHRINK  = 4'd9;
  localparam dp_op_t DP_SCAN    = 4'd10;
  localparam dp_op_t DP_EMIT    = 4'd11;

  // status returned from the datapath to the controller
  typedef struct packed {
    mode_t mode;
    logic  fail;
    logic  srch_live;
    logic  srch_hit;
    logic  up_more;
    logic  dn_more;
    logic  scan_end;
    logic  out_free;
  } dp_flags_t;

endpackage

[sv/tsmq_ram.sv]
// generic single write port ram with registered read
module tsmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/tsmq_ctrl.sv]
// controller state machine of the message queue
module tsmq_ctrl
  import tsmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_flags_t flags,
  output dp_op_t    op
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SRCH     = 4'd2;
  localparam logic [3:0] S_CMP      = 4'd3;
  localparam logic [3:0] S_SHUP     = 4'd4;
  localparam logic [3:0] S_PUT      = 4'd5;
  localparam logic [3:0] S_FETCH    = 4'd6;
  localparam logic [3:0] S_TAKE     = 4'd7;
  localparam logic [3:0] S_SHDN     = 4'd8;
  localparam logic [3:0] S_SHRINK   = 4'd9;
  localparam logic [3:0] S_SCAN     = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = DP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (flags.mode)
          MODE_INSERT: state_nxt = flags.fail ? S_EMIT : S_SRCH;
          MODE_POP, MODE_PEEK, MODE_REMOVE: state_nxt = flags.fail ? S_EMIT : S_FETCH;
          MODE_FIND: state_nxt = S_SCAN;
          default: state_nxt = S_EMIT;
        endcase
      end
      S_SRCH: begin
        if (flags.srch_live) begin
          op        = DP_PROBE;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_SHUP;
        end
      end
      S_CMP: begin
        op        = DP_COMPARE;
        state_nxt = flags.srch_hit ? S_SHUP : S_SRCH;
      end
      S_SHUP: begin
        op = DP_SHUP;
        if (!flags.up_more) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        op        = DP_PUT;
        state_nxt = S_EMIT;
      end
      S_FETCH: begin
        op        = DP_FETCH;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        op        = DP_TAKE;
        state_nxt = (flags.mode == MODE_PEEK) ? S_EMIT : S_SHDN;
      end
      S_SHDN: begin
        op = DP_SHDN;
        if (!flags.dn_more) begin
          state_nxt = S_SHRINK;
        end
      end
      S_SHRINK: begin
        op        = DP_SHRINK;
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        op = DP_SCAN;
        if (flags.scan_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (flags.out_free) begin
          op        = DP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/tsmq_dp.sv]
// datapath of the message queue: entry store, search and shift pointers, result register
module tsmq_dp
  import tsmq_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF,
  parameter int SENDER_BITS = SENDER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_op_t                 op,
  output dp_flags_t              flags,
  input  mode_t                  in_mode,
  input  logic [STAMP_BITS-1:0]  in_stamp,
  input  logic [SENDER_BITS-1:0] in_sender,
  input  logic [KIND_W-1:0]      in_msg_kind,
  input  logic                   in_ride_flag,
  input  logic [POS_W-1:0]       in_position,
  output logic                   out_valid,
  input  logic                   out_stall,
  output status_t                out_status,
  output logic [STAMP_BITS-1:0]  out_stamp,
  output logic [SENDER_BITS-1:0] out_sender,
  output logic [KIND_W-1:0]      out_kind,
  output logic                   out_ride,
  output logic [FOUND_W-1:0]     out_found_index,
  output logic [FILL_W-1:0]      out_fill_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int KEY_W = STAMP_BITS + SENDER_BITS;
  localparam int EW    = KEY_W + KIND_W + 1;

  // control state
  logic [CNT_W-1:0] count_r;
  logic             pend_r;
  logic             ov_r;

  // working registers
  mode_t            mode_r;
  logic [EW-1:0]    msg_r;
  logic [CNT_W-1:0] left_r, hi_r, pos_r, mid_r, idx_r, pend_addr_r;
  status_t          st_r;
  logic [EW-1:0]    res_r;
  logic [FOUND_W-1:0] found_r;

  // output register
  status_t            o_status_r;
  logic [EW-1:0]      o_ent_r;
  logic [FOUND_W-1:0] o_found_r;
  logic [FILL_W-1:0]  o_fill_r;

  // store port
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [EW-1:0]    wdata, rdata;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid, idx_inc, idx_dec;
  logic [KEY_W-1:0] key_new, key_ent;
  logic             key_lt, key_eq, send_match, idx_lt_cnt;

  tsmq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // midpoint of [left, hi-1], only used while left < hi
  assign mid_sum = {1'b0, left_r} + {1'b0, hi_r} - 1'b1;
  assign mid     = mid_sum[CNT_W:1];
  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;

  assign key_new    = msg_r[EW-1 -: KEY_W];
  assign key_ent    = rdata[EW-1 -: KEY_W];
  assign key_lt     = key_new < key_ent;
  assign key_eq     = key_new == key_ent;
  assign send_match = msg_r[EW-1-STAMP_BITS -: SENDER_BITS] ==
                      rdata[EW-1-STAMP_BITS -: SENDER_BITS];
  assign idx_lt_cnt = idx_r < count_r;

  always_comb begin
    case (op)
      DP_PROBE: raddr = mid[IDX_W-1:0];
      DP_SHUP:  raddr = idx_dec[IDX_W-1:0];
      DP_SHDN:  raddr = idx_inc[IDX_W-1:0];
      default:  raddr = idx_r[IDX_W-1:0];
    endcase
    we    = 1'b0;
    waddr = pend_addr_r[IDX_W-1:0];
    wdata = rdata;
    if ((op == DP_SHUP || op == DP_SHDN) && pend_r) begin
      we = 1'b1;
    end else if (op == DP_PUT) begin
      we    = 1'b1;
      waddr = pos_r[IDX_W-1:0];
      wdata = msg_r;
    end
  end

  always_comb begin
    flags.mode      = mode_r;
    flags.fail      = (st_r != ST_OK);
    flags.srch_live = left_r < hi_r;
    flags.srch_hit  = key_eq;
    flags.up_more   = pend_r || (idx_r > pos_r);
    flags.dn_more   = pend_r || (idx_inc < count_r);
    flags.scan_end  = (pend_r && send_match) || (!pend_r && !idx_lt_cnt);
    flags.out_free  = !ov_r || !out_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (op == DP_EMIT) begin
        ov_r <= 1'b1;
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
      case (op)
        DP_LOAD:   pend_r  <= 1'b0;
        DP_SHUP:   pend_r  <= idx_r > pos_r;
        DP_PUT:    count_r <= count_r + 1'b1;
        DP_SHDN:   pend_r  <= idx_inc < count_r;
        DP_SHRINK: count_r <= count_r - 1'b1;
        DP_SCAN: begin
          if (!(pend_r && send_match)) begin
            pend_r <= idx_lt_cnt;
          end
        end
        default: ;
      endcase
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: begin
        mode_r  <= in_mode;
        msg_r   <= {in_stamp, in_sender, in_msg_kind, in_ride_flag};
        res_r   <= '0;
        found_r <= '0;
        left_r  <= '0;
        hi_r    <= count_r;
        pos_r   <= count_r;
        case (in_mode)
          MODE_INSERT: begin
            idx_r <= count_r;
            st_r  <= (count_r == CNT_W'(DEPTH)) ? ST_FULL : ST_OK;
          end
          MODE_POP, MODE_PEEK: begin
            idx_r <= '0;
            st_r  <= (count_r == '0) ? ST_EMPTY : ST_OK;
          end
          MODE_REMOVE: begin
            idx_r <= CNT_W'(in_position);
            st_r  <= (CW'(in_position) >= CW'(count_r)) ? ST_BAD_INDEX : ST_OK;
          end
          MODE_FIND: begin
            idx_r <= '0;
            st_r  <= ST_NOT_FOUND;
          end
          default: begin
            idx_r <= '0;
            st_r  <= ST_OK;
          end
        endcase
      end
      DP_PROBE: mid_r <= mid;
      DP_COMPARE: begin
        if (key_lt) begin
          pos_r <= mid_r;
          hi_r  <= mid_r;
        end else if (!key_eq) begin
          left_r <= mid_r + 1'b1;
        end else begin
          pos_r <= mid_r;
        end
      end
      DP_SHUP: begin
        if (idx_r > pos_r) begin
          pend_addr_r <= idx_r;
          idx_r       <= idx_dec;
        end
      end
      DP_TAKE: res_r <= rdata;
      DP_SHDN: begin
        if (idx_inc < count_r) begin
          pend_addr_r <= idx_r;
          idx_r       <= idx_inc;
        end
      end
      DP_SCAN: begin
        if (pend_r && send_match) begin
          st_r    <= ST_OK;
          found_r <= FOUND_W'(pend_addr_r);
        end else if (idx_lt_cnt) begin
          pend_addr_r <= idx_r;
          idx_r       <= idx_inc;
        end
      end
      DP_EMIT: begin
        o_status_r <= st_r;
        o_ent_r    <= res_r;
        o_found_r  <= found_r;
        o_fill_r   <= FILL_W'(count_r);
      end
      default: ;
    endcase
  end

  assign out_valid       = ov_r;
  assign out_status      = o_status_r;
  assign out_stamp       = o_ent_r[EW-1 -: STAMP_BITS];
  assign out_sender      = o_ent_r[EW-1-STAMP_BITS -: SENDER_BITS];
  assign out_kind        = o_ent_r[KIND_W:1];
  assign out_ride        = o_ent_r[0];
  assign out_found_index = o_found_r;
  assign out_fill_count  = o_fill_r;

endmodule

[sv/timestamp_sorted_message_queue.sv]
// top level of the timestamp sorted message queue
// Holds up to DEPTH messages in a single RAM, kept in ascending order of
// {stamp, sender}; a new message equal on both keys lands where the binary
// search first hits its equal. One request beat gives exactly one result beat
// with a status and the fill count after the request. Requests are worked one
// at a time; the result sits in an output register, so a new request is taken
// while the previous result still waits on out_stall. Timing is set by the
// RAM's one write and one registered read port, which move one entry a cycle.
// An insert runs a binary search of at most clog2(DEPTH) probes, stopping on
// an equal key, then shifts the entries at and after the insert point up one
// slot and writes the new message; pop and remove read the entry, then shift
// the entries after it down; peek only reads the head; find scans from the
// head until the sender matches or the fill count is reached; a rejected
// request (full, empty, bad index) or an unused mode goes straight to the
// result. The result beat is offered once the request is done, when the next
// request can already be taken, and waits as long as a previous result is
// still stalled. No clearing pass is needed after reset: only slots below the
// fill count are ever read.
module timestamp_sorted_message_queue
  import tsmq_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF,
  parameter int SENDER_BITS = SENDER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request beat
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mode_t                  in_mode,
  input  logic [STAMP_BITS-1:0]  in_stamp,
  input  logic [SENDER_BITS-1:0] in_sender,
  input  logic [KIND_W-1:0]      in_msg_kind,
  input  logic                   in_ride_flag,
  input  logic [POS_W-1:0]       in_position,
  // result beat
  output logic                   out_valid,
  input  logic                   out_stall,
  output status_t                out_status,
  output logic [STAMP_BITS-1:0]  out_stamp,
  output logic [SENDER_BITS-1:0] out_sender,
  output logic [KIND_W-1:0]      out_kind,
  output logic                   out_ride,
  output logic [FOUND_W-1:0]     out_found_index,
  output logic [FILL_W-1:0]      out_fill_count
);

  // controller issues one datapath operation per cycle and steers on its flags
  dp_op_t    op;
  dp_flags_t flags;

  tsmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .op       (op)
  );

  // store, search pointers, shift engine and output register
  tsmq_dp #(
    .DEPTH       (DEPTH),
    .STAMP_BITS  (STAMP_BITS),
    .SENDER_BITS (SENDER_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .flags           (flags),
    .in_mode         (in_mode),
    .in_stamp        (in_stamp),
    .in_sender       (in_sender),
    .in_msg_kind     (in_msg_kind),
    .in_ride_flag    (in_ride_flag),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_stamp       (out_stamp),
    .out_sender      (out_sender),
    .out_kind        (out_kind),
    .out_ride        (out_ride),
    .out_found_index (out_found_index),
    .out_fill_count  (out_fill_count)
  );

endmodule

[sim/timestamp_sorted_message_queue_test.sv]
// self-checking test of the timestamp sorted message queue
`timescale 1ns / 1ps

module timestamp_sorted_message_queue_test
  import tsmq_pkg::*;
();

  localparam int DEPTH = DEPTH_DEF;
  localparam int SB    = STAMP_BITS_DEF;
  localparam int NB    = SENDER_BITS_DEF;

  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES = 400;
  // slowest request is an insert into a nearly full store
  localparam int TAIL_CYCLES = 60;
  localparam int REQ_TARGET  = 1600;

  // what the sender does with one entry of its list
  typedef enum logic [1:0] {ACT_SEND, ACT_DRAIN, ACT_HOLD} step_act_t;

  typedef struct packed {
    step_act_t         act;
    mode_t             mode;
    logic [SB-1:0]     stamp;
    logic [NB-1:0]     sender;
    logic [KIND_W-1:0] kind;
    logic              ride;
    logic [POS_W-1:0]  position;
  } msg_req_t;

  typedef struct packed {
    logic [SB-1:0]     stamp;
    logic [NB-1:0]     sender;
    logic [KIND_W-1:0] kind;
    logic              ride;
  } msg_slot_t;

  typedef struct packed {
    status_t            status;
    logic [SB-1:0]      stamp;
    logic [NB-1:0]      sender;
    logic [KIND_W-1:0]  kind;
    logic               ride;
    logic [FOUND_W-1:0] found;
    logic [FILL_W-1:0]  fill;
  } queue_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request side, known from time zero
  logic              in_valid     = 1'b0;
  logic              in_stall;
  mode_t             in_mode      = MODE_PEEK;
  logic [SB-1:0]     in_stamp     = '0;
  logic [NB-1:0]     in_sender    = '0;
  logic [KIND_W-1:0] in_msg_kind  = '0;
  logic              in_ride_flag = 1'b0;
  logic [POS_W-1:0]  in_position  = '0;

  // result side
  logic               out_valid;
  logic               out_stall = 1'b0;
  status_t            out_status;
  logic [SB-1:0]      out_stamp;
  logic [NB-1:0]      out_sender;
  logic [KIND_W-1:0]  out_kind;
  logic               out_ride;
  logic [FOUND_W-1:0] out_found_index;
  logic [FILL_W-1:0]  out_fill_count;

  timestamp_sorted_message_queue #(
    .DEPTH      (DEPTH),
    .STAMP_BITS (SB),
    .SENDER_BITS(NB)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_stamp       (in_stamp),
    .in_sender      (in_sender),
    .in_msg_kind    (in_msg_kind),
    .in_ride_flag   (in_ride_flag),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_stamp      (out_stamp),
    .out_sender     (out_sender),
    .out_kind       (out_kind),
    .out_ride       (out_ride),
    .out_found_index(out_found_index),
    .out_fill_count (out_fill_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sender's work list and the results owed by the block, oldest first
  msg_req_t      pend_q[$];
  queue_result_t due_q[$];

  // shadow copy of the sorted store
  msg_slot_t shadow_slots[DEPTH];
  int        shadow_count = 0;

  int errors     = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int status_seen[8];

  // sender pacing
  msg_req_t cur_req;
  int burst_left = 0;
  int gap_left   = 0;
  int hold_asks  = 0;

  // receiver pacing
  int hold_seen  = 0;
  int hold_left  = 0;
  int run_left   = 0;
  int stall_left = 0;

  // work one request against the shadow store, return the result it owes
  function automatic queue_result_t apply_request(input msg_req_t r);
    queue_result_t res;
    int lo, hi, mid, pos, idx, j;
    logic hit;
    res = '0;
    case (r.mode)
      MODE_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // binary search; an equal key stops the search on the hit
          lo  = 0;
          hi  = shadow_count - 1;
          pos = shadow_count;
          hit = 1'b0;
          while (lo <= hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (r.stamp < shadow_slots[mid].stamp ||
                (r.stamp == shadow_slots[mid].stamp &&
                 r.sender < shadow_slots[mid].sender)) begin
              pos = mid;
              hi  = mid - 1;
            end else if (r.stamp == shadow_slots[mid].stamp &&
                         r.sender == shadow_slots[mid].sender) begin
              pos = mid;
              hit = 1'b1;
            end else begin
              lo = mid + 1;
            end
          end
          for (j = shadow_count; j > pos; j--) shadow_slots[j] = shadow_slots[j-1];
          shadow_slots[pos] = '{r.stamp, r.sender, r.kind, r.ride};
          shadow_count++;
        end
      end
      MODE_POP, MODE_REMOVE: begin
        idx = (r.mode == MODE_POP) ? 0 : int'(r.position);
        if (r.mode == MODE_POP && shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (idx >= shadow_count) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.stamp  = shadow_slots[idx].stamp;
          res.sender = shadow_slots[idx].sender;
          res.kind   = shadow_slots[idx].kind;
          res.ride   = shadow_slots[idx].ride;
          // close the gap
          for (j = idx; j + 1 < shadow_count; j++) shadow_slots[j] = shadow_slots[j+1];
          shadow_count--;
        end
      end
      MODE_PEEK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.stamp  = shadow_slots[0].stamp;
          res.sender = shadow_slots[0].sender;
          res.kind   = shadow_slots[0].kind;
          res.ride   = shadow_slots[0].ride;
        end
      end
      MODE_FIND: begin
        res.status = ST_NOT_FOUND;
        for (j = 0; j < shadow_count; j++) begin
          if (res.status == ST_NOT_FOUND && shadow_slots[j].sender == r.sender) begin
            res.status = ST_OK;
            res.found  = j[FOUND_W-1:0];
          end
        end
      end
      default: begin
        // unused modes leave everything alone and report ok
      end
    endcase
    res.fill = shadow_count[FILL_W-1:0];
    return res;
  endfunction

  function automatic msg_req_t make_req(input mode_t m, input logic [SB-1:0] st,
                                        input logic [NB-1:0] sd, input logic [KIND_W-1:0] k,
                                        input logic rd, input logic [POS_W-1:0] p);
    msg_req_t r;
    r = '{ACT_SEND, m, st, sd, k, rd, p};
    return r;
  endfunction

  function automatic msg_req_t make_marker(input step_act_t a);
    msg_req_t r;
    r     = '0;
    r.act = a;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // sender: bursts of random length with random gaps, holds a stalled beat,
  // predicts each beat at the edge where it is taken
  always @(posedge clk) begin : tx_drive
    logic          offer;
    queue_result_t res;
    offer = in_valid;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        res = apply_request(cur_req);
        due_q.push_back(res);
        status_seen[res.status]++;
        n_accepted++;
        offer = 1'b0;
      end
      if (!offer && pend_q.size() > 0) begin
        if (pend_q[0].act == ACT_HOLD) begin
          // ask the receiver for its long hold-off, keep sending meanwhile
          pend_q.delete(0);
          hold_asks <= hold_asks + 1;
        end else if (pend_q[0].act == ACT_DRAIN) begin
          // pause until every owed result is back
          if (due_q.size() == 0) pend_q.delete(0);
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          cur_req = pend_q.pop_front();
          offer   = 1'b1;
          in_mode      <= cur_req.mode;
          in_stamp     <= cur_req.stamp;
          in_sender    <= cur_req.sender;
          in_msg_kind  <= cur_req.kind;
          in_ride_flag <= cur_req.ride;
          in_position  <= cur_req.position;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
    in_valid <= offer;
  end

  // receiver: own stall pattern, plus the long hold-off when asked
  always @(posedge clk) begin : rx_pace
    logic stall_nxt;
    stall_nxt = 1'b0;
    if (!rst_n) begin
      stall_nxt = 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      stall_nxt = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      stall_nxt = 1'b1;
    end else if (run_left > 0) begin
      run_left--;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_nxt = 1'b1;
    end else begin
      run_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 250)
                                               : $urandom_range(0, 30);
      stall_left = $urandom_range(0, 6);
    end
    out_stall <= stall_nxt;
  end

  // monitor: each taken result beat against the oldest owed result
  always @(posedge clk) begin : rx_check
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (due_q.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
      end else begin
        want = due_q.pop_front();
        check_field("status",      want.status, out_status);
        check_field("stamp",       want.stamp,  out_stamp);
        check_field("sender",      want.sender, out_sender);
        check_field("kind",        want.kind,   out_kind);
        check_field("ride",        want.ride,   out_ride);
        check_field("found_index", want.found,  out_found_index);
        check_field("fill_count",  want.fill,   out_fill_count);
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stim
    int n_req, n_phase, phase_len, k, bias, span, ins_pct, r;
    mode_t m;
    logic [SB-1:0] st;
    logic [NB-1:0] sd;

    // directed: empty store corner cases
    pend_q.push_back(make_req(MODE_PEEK,   '0, '0, '0, 1'b0, '0));
    pend_q.push_back(make_req(MODE_POP,    '0, '0, '0, 1'b0, '0));
    pend_q.push_back(make_req(MODE_REMOVE, '0, '0, '0, 1'b0, '0));
    pend_q.push_back(make_req(MODE_FIND,   '0, '0, '0, 1'b0, '0));
    // unused modes, all fields high on the last one
    pend_q.push_back(make_req(mode_t'(MODE_FIND + 1), '0, '0, '0, 1'b0, '0));
    pend_q.push_back(make_req(mode_t'(MODE_FIND + 2), 32'h5a5a_a5a5, 8'h3c, 8'hc3,
                              1'b0, 4'h9));
    pend_q.push_back(make_req('1, '1, '1, '1, 1'b1, '1));
    // equal keys, stamp ties broken by sender, both extremes
    pend_q.push_back(make_req(MODE_INSERT, 32'd100, 8'd5, 8'h01, 1'b0, '0));
    pend_q.push_back(make_req(MODE_INSERT, 32'd100, 8'd5, 8'h02, 1'b1, '0));
    pend_q.push_back(make_req(MODE_INSERT, 32'd100, 8'd3, 8'h03, 1'b0, '0));
    pend_q.push_back(make_req(MODE_INSERT, 32'd100, 8'd9, 8'h04, 1'b1, '0));
    pend_q.push_back(make_req(MODE_INSERT, '0, '0, '0, 1'b0, '1));
    pend_q.push_back(make_req(MODE_INSERT, '1, '1, '1, 1'b1, '0));
    pend_q.push_back(make_req(MODE_PEEK,   '0, '0, '0, 1'b0, '0));
    pend_q.push_back(make_req(MODE_FIND,   '0, 8'd5, '0, 1'b0, '0));
    pend_q.push_back(make_req(MODE_FIND,   '0, 8'd77, '0, 1'b0, '0));
    // index just past the end, far past it, last entry, a middle one
    pend_q.push_back(make_req(MODE_REMOVE, '0, '0, '0, 1'b0, 4'd6));
    pend_q.push_back(make_req(MODE_REMOVE, '0, '0, '0, 1'b0, 4'd15));
    pend_q.push_back(make_req(MODE_REMOVE, '0, '0, '0, 1'b0, 4'd5));
    pend_q.push_back(make_req(MODE_REMOVE, '0, '0, '0, 1'b0, 4'd1));
    pend_q.push_back(make_req(MODE_POP,    '0, '0, '0, 1'b0, '0));
    pend_q.push_back(make_req(MODE_POP,    '0, '0, '0, 1'b0, '0));
    pend_q.push_back(make_req(MODE_FIND,   '0, '1, '0, 1'b0, '0));
    pend_q.push_back(make_marker(ACT_DRAIN));

    // random phases: fill-heavy, drain-heavy or mixed, so the store swings
    // between empty and full; keys from a narrow set give ties and find hits
    n_req   = 0;
    n_phase = 0;
    while (n_req < REQ_TARGET) begin
      bias      = $urandom_range(0, 2);
      span      = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 80);
      ins_pct   = (bias == 0) ? 70 : (bias == 1) ? 20 : 42;
      for (k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
          m = MODE_INSERT;
        end else if (r >= 97) begin
          m = mode_t'($urandom_range(int'(MODE_FIND) + 1, (1 << MODE_W) - 1));
        end else begin
          m = mode_t'($urandom_range(int'(MODE_POP), int'(MODE_FIND)));
        end
        case (span)
          0:       st = SB'($urandom_range(0, 7));
          1:       st = SB'($urandom());
          default: st = ($urandom_range(0, 1) == 0) ? SB'($urandom_range(0, 1))
                                                    : ~SB'($urandom_range(0, 1));
        endcase
        sd = ($urandom_range(0, 1) == 0) ? NB'($urandom_range(0, 3))
                                         : NB'($urandom_range(0, 255));
        pend_q.push_back(make_req(m, st, sd, KIND_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)),
                                  POS_W'($urandom_range(0, 15))));
        if (m <= MODE_FIND) n_req++;
      end
      n_phase++;
      if (n_phase == 8) pend_q.push_back(make_marker(ACT_HOLD));
      if (n_phase % 5 == 0) pend_q.push_back(make_marker(ACT_DRAIN));
    end

    // reset held from time zero, then released once for the whole run
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the list to empty and every owed result to come back
    @(negedge clk);
    while (pend_q.size() != 0 || in_valid || due_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d requests and %0d results over %0d random phases",
             n_accepted, n_results, n_phase);
    $display("statuses: %0d ok, %0d full, %0d empty, %0d bad index, %0d not found",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BAD_INDEX], status_seen[ST_NOT_FOUND]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
